FILE: sv/tmsa4_pkg.sv
package tmsa4_pkg;

  // Config register map, decoded on paddr[2]
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH = 1'b0,
    REG_UNSWIZZLE   = 1'b1
  } reg_sel_t;

  localparam int CFG_WIDTH_W   = 11;
  localparam int WIDTH_RESET   = 256;
  localparam int PIX_W         = 4;

  // Source pixel inside an 8x8 tile
  typedef struct packed {
    logic [2:0] sy;
    logic [2:0] sx;
  } tile_xy_t;

  // One result waiting in the output queue
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } out_item_t;

  // Map an output (row, column-in-tile) to the source pixel of the tile.
  // Forward: x takes the even bits of row*8+col, y the odd bits.
  // Inverse: interleave col and row and split the result back into x and y.
  function automatic tile_xy_t tile_src(input logic [2:0] row, input logic [2:0] cx,
                                        input logic unsw);
    tile_xy_t r;
    if (!unsw) begin
      r.sx = {row[1], cx[2], cx[0]};
      r.sy = {row[2], row[0], cx[1]};
    end else begin
      r.sx = {cx[1], row[0], cx[0]};
      r.sy = {row[2], cx[2], row[1]};
    end
    return r;
  endfunction

endpackage

FILE: sv/tile_morton_swizzle_a4_pack.sv
// Reads are registered in the RAMs, then queued; one item per cycle while the queue has room
//   and no realignment runs, as even- and odd-column pixels sit in separate RAMs that each
//   take a write and a read a cycle. A write to image_width stalls the input while the read
//   position is split into row and column again, one row per cycle without config writes.
// Reset (rst_n low, synchronous) clears positions, bank select, the output queue and
//   the config registers; the band RAM is not cleared.
module tile_morton_swizzle_a4_pack #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] alpha_even, [15:8] alpha_odd
  input  logic        in_tuser,   // [0] flush
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] packed_byte
  output logic        out_tlast,  // band_end
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Each RAM holds half of both banks: bank 0 in the lower half, bank 1 above.
  localparam int DEPTH = 4 * MAX_WIDTH * 2;
  localparam int HALF  = 4 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int POS_W = $clog2(8 * MAX_WIDTH);
  localparam int SZ_W  = POS_W + 1;
  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int MAXW  = (MAX_WIDTH / 8) * 8;

  // config registers
  logic [tmsa4_pkg::CFG_WIDTH_W-1:0] iw_r, iw_nxt;
  logic                              unsw_r, unsw_nxt;

  // band positions: write index, read index, read position split as row and column
  logic [POS_W-1:0] wp_r, wp_nxt;
  logic [POS_W-1:0] rp_r, rp_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [2:0]       row_r, row_nxt;
  logic             bs_r, bs_nxt;
  logic             pv_r, pv_nxt;
  logic             align_r, align_nxt;

  // read in flight, then the output queue
  logic                 s1_v_r, s1_v_nxt;
  logic                 s1_last_r, s1_last_nxt;
  tmsa4_pkg::out_item_t fifo_r [3];
  logic [1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;

  logic             cfg_wr;
  logic             in_acc;
  logic             flush;
  logic [2:0]       occ;
  logic [W_W-1:0]   eff_w;
  logic [W_W-2:0]   hw;
  logic [SZ_W-1:0]  size_c;
  logic             col_end;
  logic             wp_end;
  logic             last;
  logic             wp_over;

  tmsa4_pkg::tile_xy_t xy_lo, xy_hi;
  logic [AW-1:0]    rbase, wbase, tile_off, prod_lo, prod_hi;
  logic [AW-1:0]    raddr_lo, raddr_hi, waddr;
  logic             ram_re, ram_we;
  logic [3:0]       ev_rdata, od_rdata;
  logic             push, pop;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign flush  = in_tuser;

  // Take an item only when the queue can absorb every result already on its way.
  assign occ       = {1'b0, cnt_r} + {2'b00, s1_v_r};
  assign in_tready = !align_r && (occ < 3'd3);
  assign in_acc    = in_tvalid && in_tready;

  // Effective width: round down to a multiple of eight, hold within 8 .. MAXW.
  always_comb begin
    if (iw_r[tmsa4_pkg::CFG_WIDTH_W-1:3] == '0) begin
      eff_w = W_W'(8);
    end else if ({iw_r[tmsa4_pkg::CFG_WIDTH_W-1:3], 3'b000} > MAXW) begin
      eff_w = W_W'(MAXW);
    end else begin
      eff_w = W_W'({iw_r[tmsa4_pkg::CFG_WIDTH_W-1:3], 3'b000});
    end
  end

  assign hw      = eff_w[W_W-1:1];
  assign size_c  = SZ_W'({eff_w, 3'b000});
  assign col_end = (SZ_W'(col_r) + SZ_W'(2)) >= SZ_W'(eff_w);
  assign wp_end  = (SZ_W'(wp_r) + SZ_W'(2)) >= size_c;
  assign wp_over = SZ_W'(wp_r) >= size_c;
  assign last    = (row_r == 3'd7) && col_end;

  // Read addresses: the first pixel of the pair is always on an even source column,
  // the second on an odd one, so each RAM sees exactly one read.
  assign xy_lo    = tmsa4_pkg::tile_src(row_r, {col_r[2:1], 1'b0}, unsw_r);
  assign xy_hi    = tmsa4_pkg::tile_src(row_r, {col_r[2:1], 1'b1}, unsw_r);
  assign rbase    = bs_r ? AW'(0) : AW'(HALF);
  assign wbase    = bs_r ? AW'(HALF) : AW'(0);
  assign tile_off = AW'({col_r[POS_W-1:3], 2'b00});
  assign prod_lo  = AW'(xy_lo.sy) * AW'(hw);
  assign prod_hi  = AW'(xy_hi.sy) * AW'(hw);
  assign raddr_lo = rbase + prod_lo + tile_off + AW'(xy_lo.sx[2:1]);
  assign raddr_hi = rbase + prod_hi + tile_off + AW'(xy_hi.sx[2:1]);
  assign waddr    = wbase + AW'(wp_r[POS_W-1:1]);

  assign ram_re = in_acc && pv_r;
  assign ram_we = in_acc && !flush;

  // Reads always go to the bank not being written, so a read and a write in the
  // same cycle never touch the same entry and need no forwarding.
  tmsa4_ram #(.WIDTH(tmsa4_pkg::PIX_W), .DEPTH(DEPTH)) u_ram_even (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_tdata[7:4]),
    .re    (ram_re),
    .raddr (raddr_lo),
    .rdata (ev_rdata)
  );

  tmsa4_ram #(.WIDTH(tmsa4_pkg::PIX_W), .DEPTH(DEPTH)) u_ram_odd (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_tdata[15:12]),
    .re    (ram_re),
    .raddr (raddr_hi),
    .rdata (od_rdata)
  );

  // Position and bank control
  always_comb begin
    iw_nxt    = iw_r;
    unsw_nxt  = unsw_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    bs_nxt    = bs_r;
    pv_nxt    = pv_r;
    align_nxt = align_r;

    if (cfg_wr) begin
      unique case (tmsa4_pkg::reg_sel_t'(paddr[2]))
        tmsa4_pkg::REG_IMAGE_WIDTH: begin
          // Width changed: restart the row/column split from the linear position.
          iw_nxt    = pwdata[tmsa4_pkg::CFG_WIDTH_W-1:0];
          align_nxt = 1'b1;
          col_nxt   = rp_r;
          row_nxt   = 3'd0;
        end
        tmsa4_pkg::REG_UNSWIZZLE: begin
          unsw_nxt = pwdata[0];
        end
        default: begin
        end
      endcase
    end else if (align_r) begin
      if (SZ_W'(col_r) >= SZ_W'(eff_w)) begin
        if (row_r == 3'd7) begin
          // Read position lies past the new band: restart it.
          rp_nxt    = '0;
          col_nxt   = '0;
          row_nxt   = 3'd0;
          align_nxt = 1'b0;
          if (wp_over) begin
            wp_nxt = '0;
          end
        end else begin
          col_nxt = col_r - POS_W'(eff_w);
          row_nxt = row_r + 3'd1;
        end
      end else begin
        align_nxt = 1'b0;
        if (wp_over) begin
          wp_nxt = '0;
        end
      end
    end else if (in_acc) begin
      if (pv_r) begin
        if (last) begin
          rp_nxt  = '0;
          col_nxt = '0;
          row_nxt = 3'd0;
          pv_nxt  = 1'b0;
        end else begin
          rp_nxt = rp_r + POS_W'(2);
          if (col_end) begin
            col_nxt = '0;
            row_nxt = row_r + 3'd1;
          end else begin
            col_nxt = col_r + POS_W'(2);
          end
        end
      end
      if (!flush) begin
        if (wp_end) begin
          // Band complete: swap banks and start emitting it from the next item.
          wp_nxt  = '0;
          bs_nxt  = !bs_r;
          pv_nxt  = 1'b1;
          rp_nxt  = '0;
          col_nxt = '0;
          row_nxt = 3'd0;
        end else begin
          wp_nxt = wp_r + POS_W'(2);
        end
      end
    end
  end

  assign s1_v_nxt    = ram_re;
  assign s1_last_nxt = last;

  // Output queue: three entries cover the read in flight plus a stalled sink.
  assign push       = s1_v_r;
  assign pop        = out_tvalid && out_tready;
  assign wr_ptr_nxt = push ? ((wr_ptr_r == 2'd2) ? 2'd0 : wr_ptr_r + 2'd1) : wr_ptr_r;
  assign rd_ptr_nxt = pop ? ((rd_ptr_r == 2'd2) ? 2'd0 : rd_ptr_r + 2'd1) : rd_ptr_r;
  assign cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = fifo_r[rd_ptr_r].data;
  assign out_tlast  = fifo_r[rd_ptr_r].last;

  always_comb begin
    unique case (tmsa4_pkg::reg_sel_t'(paddr[2]))
      tmsa4_pkg::REG_IMAGE_WIDTH: prdata = {21'd0, iw_r};
      tmsa4_pkg::REG_UNSWIZZLE:   prdata = {31'd0, unsw_r};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r     <= tmsa4_pkg::CFG_WIDTH_W'(tmsa4_pkg::WIDTH_RESET);
      unsw_r   <= 1'b0;
      wp_r     <= '0;
      rp_r     <= '0;
      col_r    <= '0;
      row_r    <= 3'd0;
      bs_r     <= 1'b0;
      pv_r     <= 1'b0;
      align_r  <= 1'b0;
      s1_v_r   <= 1'b0;
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 2'd0;
    end else begin
      iw_r     <= iw_nxt;
      unsw_r   <= unsw_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      bs_r     <= bs_nxt;
      pv_r     <= pv_nxt;
      align_r  <= align_nxt;
      s1_v_r   <= s1_v_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    s1_last_r <= s1_last_nxt;
    if (push) begin
      fifo_r[wr_ptr_r] <= '{last: s1_last_r, data: {od_rdata, ev_rdata}};
    end
  end

endmodule

FILE: sv/tmsa4_ram.sv
module tmsa4_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: sv/tmsa4_chk.sv
module tmsa4_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic        pready
);

  // Hold a stalled result item unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  // Drop every queued result on reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Stall the input while the read position is realigned to a new width.
  a_width_stall: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr[2] == tmsa4_pkg::REG_IMAGE_WIDTH)
      |=> !in_tready)
    else $error("input accepted during width realignment");

endmodule

bind tile_morton_swizzle_a4_pack tmsa4_chk u_tmsa4_chk (.*);
